>>> hw/rtl/fcmd_pkg.sv
// package for the fault code memory with debounce
// types, constants and the per-slot tick function; no dependencies
package fcmd_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);

  localparam logic [2:0] ACT_REPORT = 3'd0;
  localparam logic [2:0] ACT_TICK   = 3'd1;
  localparam logic [2:0] ACT_CLEAR  = 3'd2;
  localparam logic [2:0] ACT_READ   = 3'd3;
  localparam logic [2:0] ACT_NTH    = 3'd4;

  localparam logic [2:0] ST_EMPTY   = 3'd0;
  localparam logic [2:0] ST_PENDING = 3'd1;
  localparam logic [2:0] ST_ACTIVE  = 3'd2;
  localparam logic [2:0] ST_HEALING = 3'd3;
  localparam logic [2:0] ST_HISTORY = 3'd4;

  localparam logic [7:0] CODE_NONE = 8'hFF;
  localparam logic [7:0] SEV_NONE  = 8'hFF;
  localparam logic [3:0] DEB_MAX   = 4'd15;
  localparam logic [6:0] OCC_MAX   = 7'd127;

  // one slot entry as held in memory (35 bits)
  typedef struct packed {
    logic [7:0] code;
    logic [2:0] state;
    logic       raw;
    logic [3:0] debounce;
    logic [6:0] occurrences;
    logic [3:0] limit;
    logic [7:0] severity;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] fault_code;
    logic       raw_level;
    logic [3:0] debounce_limit;
    logic [7:0] code_severity;
    logic [3:0] position;
  } req_t;

  typedef struct packed {
    logic [4:0] used_count;
    logic [4:0] active_count;
    logic [7:0] top_severity;
    logic [7:0] found_code;
    logic [6:0] found_occurrences;
    logic [2:0] found_state;
    logic [7:0] found_severity;
  } rsp_t;

  function automatic slot_t tick_slot(input slot_t s);
    slot_t      r;
    logic [3:0] d;
    logic       reached;
    r = s;
    d = (s.debounce == DEB_MAX) ? s.debounce : s.debounce + 4'd1;
    r.debounce = d;
    reached = (d >= s.limit) || (d == DEB_MAX);
    case (s.state)
      ST_PENDING: begin
        if (s.raw) begin
          if (reached) begin
            if (s.occurrences != OCC_MAX) r.occurrences = s.occurrences + 7'd1;
            r.state = ST_ACTIVE;
            r.debounce = 4'd0;
          end
        end else begin
          r.state = ST_HISTORY;
          r.debounce = 4'd0;
        end
      end
      ST_ACTIVE: begin
        if (!s.raw) begin
          r.state = ST_HEALING;
          r.debounce = 4'd1;
        end
      end
      ST_HEALING: begin
        if (!s.raw) begin
          if (reached) begin
            r.state = ST_HISTORY;
            r.debounce = 4'd0;
          end
        end else begin
          r.state = ST_ACTIVE;
          r.debounce = 4'd0;
        end
      end
      ST_HISTORY: begin
        if (s.raw) begin
          r.state = ST_PENDING;
          r.debounce = 4'd1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/fcmd_req_if.sv
// valid/ready channel interface carrying one request word
// depends on fcmd_pkg
interface fcmd_req_if;
  logic           valid;
  logic           ready;
  fcmd_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/fcmd_rsp_if.sv
// valid/ready channel interface carrying one result word
// depends on fcmd_pkg
interface fcmd_rsp_if;
  logic           valid;
  logic           ready;
  fcmd_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/fcmd_ram.sv
// generic single-port-write, single-read ram with registered read
// no dependencies
module fcmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/fault_code_memory_debounce.sv
// fault code memory with debounce: a sequencer over one slot ram
// each word takes two sweeps over the slots, a search sweep and then an update sweep, and the
// result is offered after them; no new word is taken until that result has been accepted
// reset runs a clearing pass over every slot before the first word is taken
// depends on fcmd_pkg, fcmd_req_if, fcmd_rsp_if, fcmd_ram
module fault_code_memory_debounce (
  input logic            clk,
  input logic            rst,
  fcmd_req_if.sink       req,
  fcmd_rsp_if.source     rsp
);
  localparam int IW = fcmd_pkg::IDX_W;
  localparam int CW = IW + 1;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SRCH  = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]          state;
  logic [CW-1:0]       cnt;
  fcmd_pkg::req_t      cur;
  fcmd_pkg::slot_t     rdata;
  logic                we;
  logic [IW-1:0]       waddr;
  fcmd_pkg::slot_t     wdata;
  logic [IW-1:0]       raddr;
  logic [IW-1:0]       prev;

  // search results
  logic                match_found, empty_found, hist_found;
  logic [IW-1:0]       match_idx, empty_idx, hist_idx;
  // summary
  logic [CW-1:0]       used, active;
  logic [7:0]          top;
  logic                hit;
  fcmd_pkg::slot_t     hit_slot;
  fcmd_pkg::rsp_t      out_word;

  logic                rd_phase;
  logic [IW-1:0]       sidx;
  fcmd_pkg::slot_t     newv;
  logic                target;
  logic [IW-1:0]       pick;
  logic                pick_ok;

  fcmd_ram #(.WIDTH(fcmd_pkg::SLOT_W), .DEPTH(fcmd_pkg::SLOTS)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.data  = out_word;

  // cnt 0 issues read of slot 0; cnt k>0 sees slot k-1
  assign raddr    = cnt[IW-1:0];
  assign rd_phase = (cnt != '0);
  assign sidx     = prev;
  assign pick     = empty_found ? empty_idx : hist_idx;
  assign pick_ok  = empty_found || hist_found;

  always_comb begin
    newv = rdata;
    target = 1'b0;
    unique case (cur.action)
      fcmd_pkg::ACT_REPORT: begin
        if (match_found && sidx == match_idx) begin
          newv.raw = cur.raw_level;
          target = 1'b1;
        end else if (!match_found && cur.raw_level && pick_ok && sidx == pick) begin
          newv.code = cur.fault_code;
          newv.state = fcmd_pkg::ST_PENDING;
          newv.raw = 1'b1;
          newv.debounce = 4'd0;
          newv.occurrences = 7'd0;
          newv.limit = cur.debounce_limit;
          newv.severity = cur.code_severity;
          target = 1'b1;
        end
      end
      fcmd_pkg::ACT_TICK: begin
        newv = fcmd_pkg::tick_slot(rdata);
        target = 1'b1;
      end
      fcmd_pkg::ACT_CLEAR: begin
        newv.code = fcmd_pkg::CODE_NONE;
        newv.state = fcmd_pkg::ST_EMPTY;
        newv.raw = 1'b0;
        newv.debounce = 4'd0;
        newv.occurrences = 7'd0;
        target = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = sidx;
    wdata = newv;
    if (state == S_INIT) begin
      we = 1'b1;
      waddr = cnt[IW-1:0];
      wdata = '0;
      wdata.code = fcmd_pkg::CODE_NONE;
    end else if (state == S_UPD && rd_phase) begin
      we = target;
    end
  end

  always_comb begin
    out_word.used_count = used;
    out_word.active_count = active;
    out_word.top_severity = top;
    if (hit) begin
      out_word.found_code = hit_slot.code;
      out_word.found_occurrences = hit_slot.occurrences;
      out_word.found_state = hit_slot.state;
      out_word.found_severity = hit_slot.severity;
    end else begin
      out_word.found_code = fcmd_pkg::CODE_NONE;
      out_word.found_occurrences = 7'd0;
      out_word.found_state = fcmd_pkg::ST_EMPTY;
      out_word.found_severity = fcmd_pkg::SEV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    prev <= cnt[IW-1:0];
    if (rst) begin
      state <= S_INIT;
      cnt <= '0;
    end else begin
      unique case (state)
        S_INIT: begin
          if (cnt == CW'(fcmd_pkg::SLOTS - 1)) begin
            state <= S_IDLE;
            cnt <= '0;
          end else cnt <= cnt + 1'b1;
        end
        S_IDLE: begin
          if (req.valid) begin
            cur <= req.data;
            state <= S_SRCH;
            cnt <= '0;
            match_found <= 1'b0;
            empty_found <= 1'b0;
            hist_found <= 1'b0;
          end
        end
        S_SRCH: begin
          if (rd_phase) begin
            if (!match_found && rdata.state != fcmd_pkg::ST_EMPTY
                && rdata.code == cur.fault_code) begin
              match_found <= 1'b1;
              match_idx <= sidx;
            end
            if (!empty_found && rdata.state == fcmd_pkg::ST_EMPTY) begin
              empty_found <= 1'b1;
              empty_idx <= sidx;
            end
            if (!hist_found && rdata.state == fcmd_pkg::ST_HISTORY) begin
              hist_found <= 1'b1;
              hist_idx <= sidx;
            end
          end
          if (cnt == CW'(fcmd_pkg::SLOTS)) begin
            state <= S_UPD;
            cnt <= '0;
            used <= '0;
            active <= '0;
            top <= 8'd0;
            hit <= 1'b0;
          end else cnt <= cnt + 1'b1;
        end
        S_UPD: begin
          if (rd_phase) begin
            if (newv.state != fcmd_pkg::ST_EMPTY) used <= used + 1'b1;
            if (newv.state == fcmd_pkg::ST_ACTIVE) begin
              active <= active + 1'b1;
              if (newv.severity != fcmd_pkg::SEV_NONE && newv.severity > top)
                top <= newv.severity;
              if (cur.action == fcmd_pkg::ACT_NTH && !hit
                  && active == {1'b0, cur.position}) begin
                hit <= 1'b1;
                hit_slot <= newv;
              end
            end
            if (cur.action == fcmd_pkg::ACT_READ && sidx == cur.position[IW-1:0]
                && newv.state != fcmd_pkg::ST_EMPTY) begin
              hit <= 1'b1;
              hit_slot <= newv;
            end
          end
          if (cnt == CW'(fcmd_pkg::SLOTS)) state <= S_OUT;
          else cnt <= cnt + 1'b1;
        end
        S_OUT: begin
          if (rsp.ready) begin
            state <= S_IDLE;
            cnt <= '0;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !rsp.valid) else $error("ready while result pending");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> active <= used) else $error("active above used");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_OUT || state == S_SRCH) |-> !we)
    else $error("write outside update sweep");
  a_out_after_upd: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_UPD) else $error("result without sweep");
endmodule
